FILE: sv/lcc_pkg.sv
// ----------------------------------------------------------------------------
// lcc_pkg: shared types, tables and helpers for the LCD color correction.
// Holds the gamma intensity table, the crosstalk matrix and the field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package lcc_pkg;

    localparam int unsigned CHAN_W    = 8;
    localparam int unsigned INDEX_W   = 5;
    localparam int unsigned LEVEL_W   = 8;
    localparam int unsigned WEIGHT_W  = 5;
    localparam int unsigned CONTRIB_W = 7;
    localparam int unsigned NUM_CHAN  = 3;
    localparam int unsigned LEVEL_SHIFT = 5;

    localparam logic [CHAN_W-1:0] OUT_OFFSET = 8'd32;

    typedef logic [CHAN_W-1:0]    chan_t;
    typedef logic [INDEX_W-1:0]   index_t;
    typedef logic [LEVEL_W-1:0]   level_t;
    typedef logic [WEIGHT_W-1:0]  weight_t;
    typedef logic [CONTRIB_W-1:0] contrib_t;

    // Rows are source channels, columns are displayed channels.
    localparam weight_t CROSSTALK [NUM_CHAN][NUM_CHAN] = '{
        '{5'd16, 5'd4,  5'd4 },
        '{5'd8,  5'd16, 5'd8 },
        '{5'd0,  5'd8,  5'd16}
    };

    function automatic level_t gamma_level(input index_t idx);
        level_t lvl;
        case (idx)
            5'd0:    lvl = 8'h00;
            5'd1:    lvl = 8'h10;
            5'd2:    lvl = 8'h20;
            5'd3:    lvl = 8'h30;
            5'd4:    lvl = 8'h40;
            5'd5:    lvl = 8'h50;
            5'd6:    lvl = 8'h5e;
            5'd7:    lvl = 8'h6c;
            5'd8:    lvl = 8'h7a;
            5'd9:    lvl = 8'h88;
            5'd10:   lvl = 8'h94;
            5'd11:   lvl = 8'ha0;
            5'd12:   lvl = 8'hae;
            5'd13:   lvl = 8'hb7;
            5'd14:   lvl = 8'hbf;
            5'd15:   lvl = 8'hc6;
            5'd16:   lvl = 8'hce;
            5'd17:   lvl = 8'hd3;
            5'd18:   lvl = 8'hd9;
            5'd19:   lvl = 8'hdf;
            5'd20:   lvl = 8'he3;
            5'd21:   lvl = 8'he7;
            5'd22:   lvl = 8'heb;
            5'd23:   lvl = 8'hef;
            5'd24:   lvl = 8'hf3;
            5'd25:   lvl = 8'hf6;
            5'd26:   lvl = 8'hf9;
            5'd27:   lvl = 8'hfb;
            5'd28:   lvl = 8'hfd;
            5'd29:   lvl = 8'hfe;
            default: lvl = 8'hff;
        endcase
        return lvl;
    endfunction

    function automatic contrib_t crosstalk_term(input level_t lvl, input weight_t w);
        logic [LEVEL_W+WEIGHT_W-1:0] prod;
        prod = lvl * w;
        return prod[LEVEL_SHIFT +: CONTRIB_W];
    endfunction

endpackage

`default_nettype wire

FILE: sv/lcc_in_if.sv
// ----------------------------------------------------------------------------
// lcc_in_if: source pixel channel.
// Carries one RGB888 pixel item with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcc_in_if
    import lcc_pkg::*;
();
    logic  valid;
    logic  ready;
    chan_t red_in;
    chan_t green_in;
    chan_t blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

`default_nettype wire

FILE: sv/lcc_out_if.sv
// ----------------------------------------------------------------------------
// lcc_out_if: corrected pixel channel.
// Carries one displayed RGB pixel item with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcc_out_if
    import lcc_pkg::*;
();
    logic  valid;
    logic  ready;
    chan_t red_out;
    chan_t green_out;
    chan_t blue_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                     input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    output ready);
endinterface

`default_nettype wire

FILE: sv/lcc_mix.sv
// ----------------------------------------------------------------------------
// lcc_mix: combines three crosstalk terms into one displayed channel.
// Sorts the terms ascending, weighs them 1, 2 and 4, scales by 5/16, offsets.
// ----------------------------------------------------------------------------
`default_nettype none

module lcc_mix
    import lcc_pkg::*;
(
    input  var contrib_t term [NUM_CHAN],
    output var chan_t    level
);

    contrib_t    a0, b0, a1, b1, lo, mid, hi;
    logic [9:0]  weighted;
    logic [12:0] scaled;
    logic [8:0]  shifted;

    always_comb
    begin
        a0 = (term[0] > term[1]) ? term[1] : term[0];
        b0 = (term[0] > term[1]) ? term[0] : term[1];
        a1 = (b0 > term[2]) ? term[2] : b0;
        hi = (b0 > term[2]) ? b0 : term[2];
        lo  = (a0 > a1) ? a1 : a0;
        mid = (a0 > a1) ? a0 : a1;
        weighted = 10'(lo) + {2'b0, mid, 1'b0} + {1'b0, hi, 2'b0};
        scaled   = {weighted, 2'b0} + 13'(weighted);
        shifted  = scaled[12:4];
        level    = shifted[CHAN_W-1:0] + OUT_OFFSET;
    end

endmodule

`default_nettype wire

FILE: sv/lcd_color_correction_top.sv
// ----------------------------------------------------------------------------
// lcd_color_correction_top: handheld LCD color correction for RGB888 pixels.
//
// Each item on pixel_in is one source pixel; only bits 7..3 of every channel
// are used. Each item on pixel_out is the color the LCD would show, with
// every channel in the range 32 to 239. Exactly one result item leaves for
// every accepted pixel, in order.
//
// The block is a two-stage pipeline: an input register holds the pixel, the
// gamma lookup, crosstalk, sort and scaling run in one combinational pass,
// and an output register holds the result. An accepted pixel is captured
// in the input register and its result in the output register, and one
// pixel can be accepted every cycle while the receiver keeps taking results.
//
// When the receiver stalls, the output register holds its result and the
// input register can still take one more pixel before ready drops. Reset
// empties both stages; there is no other state.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_color_correction_top
    import lcc_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    lcc_in_if.sink     pixel_in,
    lcc_out_if.source  pixel_out
);

    logic     in_valid_reg, in_valid_next;
    chan_t    in_pix_reg  [NUM_CHAN];
    logic     out_valid_reg, out_valid_next;
    chan_t    out_pix_reg [NUM_CHAN];
    logic     out_ready, in_ready;
    level_t   lvl [NUM_CHAN];
    contrib_t term [NUM_CHAN][NUM_CHAN];
    chan_t    result [NUM_CHAN];

    assign out_ready = !out_valid_reg || pixel_out.ready;
    assign in_ready  = !in_valid_reg || out_ready;

    always_comb
    begin
        in_valid_next  = pixel_in.valid || (in_valid_reg && !out_ready);
        out_valid_next = in_valid_reg || (out_valid_reg && !pixel_out.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid_next;
            end
            if (out_ready)
            begin
                out_valid_reg <= out_valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && pixel_in.valid)
        begin
            in_pix_reg[0] <= pixel_in.red_in;
            in_pix_reg[1] <= pixel_in.green_in;
            in_pix_reg[2] <= pixel_in.blue_in;
        end
        if (out_ready && in_valid_reg)
        begin
            out_pix_reg <= result;
        end
    end

    always_comb
    begin
        for (int s = 0; s < NUM_CHAN; s++)
        begin
            lvl[s] = gamma_level(in_pix_reg[s][CHAN_W-1 -: INDEX_W]);
        end
        for (int d = 0; d < NUM_CHAN; d++)
        begin
            for (int s = 0; s < NUM_CHAN; s++)
            begin
                term[d][s] = crosstalk_term(lvl[s], CROSSTALK[s][d]);
            end
        end
    end

    for (genvar d = 0; d < NUM_CHAN; d++)
    begin : g_mix
        lcc_mix u_mix (
            .term  (term[d]),
            .level (result[d])
        );
    end

    assign pixel_in.ready      = in_ready;
    assign pixel_out.valid     = out_valid_reg;
    assign pixel_out.red_out   = out_pix_reg[0];
    assign pixel_out.green_out = out_pix_reg[1];
    assign pixel_out.blue_out  = out_pix_reg[2];

endmodule

`default_nettype wire

FILE: sv/lcc_checker.sv
// ----------------------------------------------------------------------------
// lcc_port_checks: port-level checks for the LCD color correction.
// Watches the pixel channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lcc_port_checks
    import lcc_pkg::*;
(
    input wire       clk,
    input wire       rst_n,
    input wire       in_valid,
    input wire       in_ready,
    input wire       out_valid,
    input wire       out_ready,
    input var chan_t red_out,
    input var chan_t green_out,
    input var chan_t blue_out
);

    localparam chan_t OUT_MAX = 8'd239;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red_out)
            && $stable(green_out) && $stable(blue_out))
        else $error("stalled result item changed");

    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> red_out >= OUT_OFFSET && red_out <= OUT_MAX
            && green_out >= OUT_OFFSET && green_out <= OUT_MAX
            && blue_out >= OUT_OFFSET && blue_out <= OUT_MAX)
        else $error("result item outside displayable range");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output stage is empty");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result item appeared without a pixel two cycles before");

endmodule

bind lcd_color_correction_top lcc_port_checks u_lcc_port_checks (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pixel_in.valid),
    .in_ready  (pixel_in.ready),
    .out_valid (pixel_out.valid),
    .out_ready (pixel_out.ready),
    .red_out   (pixel_out.red_out),
    .green_out (pixel_out.green_out),
    .blue_out  (pixel_out.blue_out)
);

`default_nettype wire
